/* design/cce_pkg.sv */
`default_nettype none

package cce_pkg;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CRC_W       = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_BYTES        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_POLYNOMIAL         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INIT_VALUE         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_IN         = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REFLECT_OUT        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_XOR_OUT            = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_REGISTER_REFLECTED = 3'd6;

  // Reset values of the configuration (standard CRC-32).
  localparam logic [3:0]       RST_WIDTH_BYTES = 4'd4;
  localparam logic [CRC_W-1:0] RST_POLYNOMIAL  = 64'h0000_0000_04C1_1DB7;
  localparam logic [CRC_W-1:0] RST_INIT_VALUE  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [CRC_W-1:0] RST_XOR_OUT     = 64'h0000_0000_FFFF_FFFF;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [3:0]       width_bytes;
    logic [CRC_W-1:0] polynomial;
    logic [CRC_W-1:0] init_value;
    logic             reflect_in;
    logic             reflect_out;
    logic [CRC_W-1:0] xor_out;
    logic             register_reflected;
  } cfg_t;

endpackage

`default_nettype wire

/* design/cce_if.sv */
`default_nettype none

// Byte stream into the engine.
interface cce_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Finished CRC values out of the engine.
interface cce_crc_if;
  logic                       valid;
  logic                       ready;
  logic [cce_pkg::CRC_W-1:0]  crc_value;

  modport source (output valid, output crc_value, input ready);
  modport sink   (input valid, input crc_value, output ready);
endinterface

`default_nettype wire

/* design/cce_cfg_regs.sv */
`default_nettype none

module cce_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write_en,
  input  wire logic [cce_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [cce_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cce_pkg::cfg_t                         cfg
);

  // Register file: one write per cycle, indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_bytes        <= cce_pkg::RST_WIDTH_BYTES;
      cfg.polynomial         <= cce_pkg::RST_POLYNOMIAL;
      cfg.init_value         <= cce_pkg::RST_INIT_VALUE;
      cfg.reflect_in         <= 1'b1;
      cfg.reflect_out        <= 1'b1;
      cfg.xor_out            <= cce_pkg::RST_XOR_OUT;
      cfg.register_reflected <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        cce_pkg::REG_WIDTH_BYTES:        cfg.width_bytes        <= cfg_data[3:0];
        cce_pkg::REG_POLYNOMIAL:         cfg.polynomial         <= cfg_data;
        cce_pkg::REG_INIT_VALUE:         cfg.init_value         <= cfg_data;
        cce_pkg::REG_REFLECT_IN:         cfg.reflect_in         <= cfg_data[0];
        cce_pkg::REG_REFLECT_OUT:        cfg.reflect_out        <= cfg_data[0];
        cce_pkg::REG_XOR_OUT:            cfg.xor_out            <= cfg_data;
        cce_pkg::REG_REGISTER_REFLECTED: cfg.register_reflected <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/cce_step.sv */
`default_nettype none

module cce_step (
  input  wire cce_pkg::cfg_t                  cfg,
  input  wire logic [cce_pkg::CRC_W-1:0]      crc_state,
  input  wire logic                           in_message,
  input  wire logic [7:0]                     data_byte,
  output logic      [cce_pkg::CRC_W-1:0]      crc_next,
  output logic      [cce_pkg::CRC_W-1:0]      crc_result
);

  logic [3:0]                  width_clamped;
  logic [6:0]                  width_bits;
  logic [5:0]                  rev_shift;
  logic [5:0]                  top_idx;
  logic [cce_pkg::CRC_W-1:0]   mask;
  logic [cce_pkg::CRC_W-1:0]   poly;
  logic [cce_pkg::CRC_W-1:0]   init_left;
  logic [cce_pkg::CRC_W-1:0]   acc;
  logic [cce_pkg::CRC_W-1:0]   left_form;
  logic [cce_pkg::CRC_W-1:0]   shaped;
  logic                        din;
  logic                        fb;

  // Bit reverse within the CRC width: full reverse, then drop the unused low bits.
  function automatic logic [cce_pkg::CRC_W-1:0] rev_w(
    input logic [cce_pkg::CRC_W-1:0] v,
    input logic [5:0]                sh
  );
    logic [cce_pkg::CRC_W-1:0] r;
    for (int i = 0; i < cce_pkg::CRC_W; i++) begin
      r[i] = v[cce_pkg::CRC_W-1-i];
    end
    return r >> sh;
  endfunction

  // Width decode; zero acts as one byte, values above eight as eight.
  always_comb begin
    if (cfg.width_bytes == 4'd0) begin
      width_clamped = 4'd1;
    end else if (cfg.width_bytes > 4'd8) begin
      width_clamped = 4'd8;
    end else begin
      width_clamped = cfg.width_bytes;
    end
    width_bits = {width_clamped, 3'b000};
    rev_shift  = 6'(7'd64 - width_bits);
    top_idx    = 6'(width_bits - 7'd1);
    mask       = {cce_pkg::CRC_W{1'b1}} >> rev_shift;
    poly       = cfg.polynomial & mask;
    init_left  = cfg.init_value & mask;
  end

  // Eight unrolled XOR-shift steps, starting from the initial value on a new message.
  always_comb begin
    if (in_message) begin
      acc = crc_state & mask;
    end else if (cfg.register_reflected) begin
      acc = rev_w(init_left, rev_shift);
    end else begin
      acc = init_left;
    end
    din = 1'b0;
    fb  = 1'b0;
    for (int j = 0; j < 8; j++) begin
      din = cfg.reflect_in ? data_byte[j] : data_byte[7-j];
      if (cfg.register_reflected) begin
        fb  = acc[0] ^ din;
        acc = acc >> 1;
      end else begin
        fb  = acc[top_idx] ^ din;
        acc = (acc << 1) & mask;
      end
      if (fb) begin
        acc = acc ^ poly;
      end
    end
    crc_next = acc;
  end

  // Finish: back to left form, optional output reflection, then the final XOR.
  always_comb begin
    left_form  = cfg.register_reflected ? rev_w(acc, rev_shift) : acc;
    shaped     = cfg.reflect_out ? rev_w(left_form, rev_shift) : left_form;
    crc_result = (shaped ^ cfg.xor_out) & mask;
  end

endmodule

`default_nettype wire

/* design/configurable_crc_engine.sv */
`default_nettype none

// Channel    Dir  Payload                     Transaction when
// byte_in    in   data_byte[7:0], last_byte   valid && ready
// crc_out    out  crc_value[63:0]             valid && ready
// cfg_*      in   cfg_index[2:0], cfg_data    cfg_write_en
//
// One byte per cycle sustained while no last byte waits on crc_out; a byte
// accepted on byte_in is processed by the eight-step XOR-shift datapath out of the
// input register, and a last byte's CRC is registered and offered on crc_out from then on.
// Reset (rst, synchronous) empties both registers and marks no message open.
// A CRC waiting on crc_out holds the next last byte in the input register, and
// byte_in stalls until that CRC leaves; other bytes never wait on crc_out.

module configurable_crc_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  cce_byte_if.sink                              byte_in,
  cce_crc_if.source                             crc_out,
  input  wire logic                             cfg_write_en,
  input  wire logic [cce_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [cce_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cce_pkg::cfg_t              cfg;
  logic                       in_valid;
  logic [7:0]                 in_data;
  logic                       in_last;
  logic                       out_valid;
  logic [cce_pkg::CRC_W-1:0]  out_crc;
  logic [cce_pkg::CRC_W-1:0]  crc_reg;
  logic                       in_message;
  logic [cce_pkg::CRC_W-1:0]  crc_next;
  logic [cce_pkg::CRC_W-1:0]  crc_result;
  logic                       out_free;
  logic                       advance;

  cce_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  cce_step u_step (
    .cfg        (cfg),
    .crc_state  (crc_reg),
    .in_message (in_message),
    .data_byte  (in_data),
    .crc_next   (crc_next),
    .crc_result (crc_result)
  );

  // The held byte moves on unless it is a last byte facing an occupied result slot.
  assign out_free      = !out_valid || crc_out.ready;
  assign advance       = in_valid && (!in_last || out_free);
  assign byte_in.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_in.ready) begin
      in_valid <= byte_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.ready && byte_in.valid) begin
      in_data <= byte_in.data_byte;
      in_last <= byte_in.last_byte;
    end
  end

  // CRC state; a last byte closes the message so the next one reloads the initial value.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_message <= 1'b0;
    end else if (advance) begin
      in_message <= !in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      crc_reg <= crc_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (crc_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_crc <= crc_result;
    end
  end

  assign crc_out.valid     = out_valid;
  assign crc_out.crc_value = out_crc;

  // A new result only ever comes from a last byte.
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> out_valid)
    else $error("result not presented after a last byte");

  a_message_closes: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> !in_message)
    else $error("message still open after a last byte");

  a_message_opens: assert property (@(posedge clk) disable iff (rst)
    (advance && !in_last) |=> in_message)
    else $error("message not open after a middle byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !crc_out.ready) |-> !(advance && in_last))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* tb/crc_stream_checker.sv */
`timescale 1ns / 100ps

// Watches the byte stream, the register writes and the CRC stream of the engine.
// Every accepted last byte yields one expected CRC, and each CRC transaction on
// the output is compared with the oldest expected one.
module crc_stream_checker (
  input  logic                            clk,
  input  logic                            rst,
  cce_byte_if                             byte_mon,
  cce_crc_if                              crc_mon,
  input  logic                            cfg_write_en,
  input  logic [cce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cce_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                     mismatch_count,
  output int unsigned                     crc_pending
);

  localparam int unsigned REPORT_LIMIT = 10;

  cce_pkg::cfg_t             settings;
  logic [cce_pkg::CRC_W-1:0] crc_state;
  logic                      msg_open;
  logic [cce_pkg::CRC_W-1:0] crc_expected_q[$];
  int unsigned               errors = 0;
  int unsigned               pending = 0;

  assign mismatch_count = errors;
  assign crc_pending    = pending;

  // Width codes outside 1..8 saturate to the nearest legal width.
  function automatic int unsigned crc_width_bits(input logic [3:0] width_bytes);
    if (width_bytes == 4'd0) return 8;
    if (width_bytes > 4'd8) return 64;
    return 8 * int'(width_bytes);
  endfunction

  function automatic logic [cce_pkg::CRC_W-1:0] low_mask(input int unsigned w);
    if (w >= 64) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  function automatic logic [cce_pkg::CRC_W-1:0] bit_reverse(
    input logic [cce_pkg::CRC_W-1:0] v,
    input int unsigned               w
  );
    logic [cce_pkg::CRC_W-1:0] r;
    int unsigned               i;
    r = '0;
    for (i = 0; i < w; i++) r[w-1-i] = v[i];
    return r;
  endfunction

  // Register contents at the start of a message: the reflected register holds
  // the bit-reverse of the left-form initial value.
  function automatic logic [cce_pkg::CRC_W-1:0] register_start(input cce_pkg::cfg_t s);
    int unsigned               w;
    logic [cce_pkg::CRC_W-1:0] v;
    w = crc_width_bits(s.width_bytes);
    v = s.init_value & low_mask(w);
    return s.register_reflected ? bit_reverse(v, w) : v;
  endfunction

  function automatic cce_pkg::cfg_t reset_settings();
    cce_pkg::cfg_t s;
    s.width_bytes        = cce_pkg::RST_WIDTH_BYTES;
    s.polynomial         = cce_pkg::RST_POLYNOMIAL;
    s.init_value         = cce_pkg::RST_INIT_VALUE;
    s.reflect_in         = 1'b1;
    s.reflect_out        = 1'b1;
    s.xor_out            = cce_pkg::RST_XOR_OUT;
    s.register_reflected = 1'b0;
    return s;
  endfunction

  // Runs one byte through the register bit by bit; a last byte finishes the CRC,
  // queues it and leaves the message closed.
  function automatic void absorb_byte(input logic [7:0] data, input logic last);
    int unsigned               w;
    int unsigned               j;
    logic [cce_pkg::CRC_W-1:0] mask;
    logic [cce_pkg::CRC_W-1:0] poly;
    logic [cce_pkg::CRC_W-1:0] crc_next;
    logic [cce_pkg::CRC_W-1:0] result;
    logic                      in_bit;
    logic                      feedback;
    w    = crc_width_bits(settings.width_bytes);
    mask = low_mask(w);
    poly = settings.polynomial & mask;
    if (!msg_open) crc_state = register_start(settings);
    crc_next = crc_state & mask;
    for (j = 0; j < 8; j++) begin
      in_bit = settings.reflect_in ? data[j] : data[7-j];
      if (settings.register_reflected) begin
        feedback = crc_next[0] ^ in_bit;
        crc_next = crc_next >> 1;
      end else begin
        feedback = crc_next[w-1] ^ in_bit;
        crc_next = (crc_next << 1) & mask;
      end
      if (feedback) crc_next = crc_next ^ poly;
    end
    crc_state = crc_next;
    if (last) begin
      result = settings.register_reflected ? bit_reverse(crc_next, w) : crc_next;
      if (settings.reflect_out) result = bit_reverse(result, w);
      crc_expected_q.push_back((result ^ settings.xor_out) & mask);
      crc_state = register_start(settings);
    end
    msg_open = !last;
  endfunction

  // Everything is sampled at the rising edge; writes and byte transactions never
  // share an edge, and a CRC cannot leave on the edge its last byte enters.
  always @(posedge clk) begin : track
    logic [cce_pkg::CRC_W-1:0] wanted;
    if (rst) begin
      settings  = reset_settings();
      crc_state = register_start(settings);
      msg_open  = 1'b0;
      crc_expected_q.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          cce_pkg::REG_WIDTH_BYTES:        settings.width_bytes        = cfg_data[3:0];
          cce_pkg::REG_POLYNOMIAL:         settings.polynomial         = cfg_data;
          cce_pkg::REG_INIT_VALUE:         settings.init_value         = cfg_data;
          cce_pkg::REG_REFLECT_IN:         settings.reflect_in         = cfg_data[0];
          cce_pkg::REG_REFLECT_OUT:        settings.reflect_out        = cfg_data[0];
          cce_pkg::REG_XOR_OUT:            settings.xor_out            = cfg_data;
          cce_pkg::REG_REGISTER_REFLECTED: settings.register_reflected = cfg_data[0];
          default: ;
        endcase
      end

      // Compare the outgoing CRC with the oldest one still owed.
      if (crc_mon.valid && crc_mon.ready) begin
        if (crc_expected_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected CRC %h with nothing pending", $realtime,
                     crc_mon.crc_value);
        end else begin
          wanted = crc_expected_q.pop_front();
          if (crc_mon.crc_value !== wanted) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: CRC mismatch, expected %h, got %h", $realtime, wanted,
                       crc_mon.crc_value);
          end
        end
      end

      if (byte_mon.valid && byte_mon.ready)
        absorb_byte(byte_mon.data_byte, byte_mon.last_byte);
    end
    pending = crc_expected_q.size();
  end

endmodule

/* tb/configurable_crc_engine_tb.sv */
`timescale 1ns / 100ps

module configurable_crc_engine_tb;

  localparam int unsigned ITEM_TARGET     = 1450;
  localparam int unsigned CALM_ITEMS      = 150;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned PRESSURE_PHASE  = 3;
  localparam logic [cce_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_write_en = 1'b0;
  logic [cce_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cce_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  bit                              idling_on = 1'b1;
  bit                              hold_off_req = 1'b0;
  int unsigned                     items_sent = 0;
  int unsigned                     stall_cycles = 0;
  int unsigned                     mismatch_count;
  int unsigned                     crc_pending;

  cce_byte_if byte_if ();
  cce_crc_if  crc_if ();

  configurable_crc_engine dut (
    .clk          (clk),
    .rst          (rst),
    .byte_in      (byte_if),
    .crc_out      (crc_if),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  crc_stream_checker crc_check (
    .clk            (clk),
    .rst            (rst),
    .byte_mon       (byte_if),
    .crc_mon        (crc_if),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .crc_pending    (crc_pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Ends the run when no transaction and no register write happens for too long.
  always @(posedge clk) begin
    if (rst || (byte_if.valid && byte_if.ready) || (crc_if.valid && crc_if.ready) ||
        cfg_write_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, stall_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // CRC receiver: random stall bursts, plus one long hold-off on request.
  initial begin : crc_receiver
    crc_if.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        crc_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        crc_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        crc_if.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] corner_or_random();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic int unsigned message_length();
    if ($urandom_range(0, 4) == 0) return $urandom_range(9, 40);
    return $urandom_range(1, 8);
  endfunction

  // Sometimes fills the bits above a narrow register with junk, which it ignores.
  function automatic logic [63:0] pad_register(input logic [63:0] v,
                                               input int unsigned bits);
    if ($urandom_range(0, 3) == 0) return v | (rand64() & ~((64'd1 << bits) - 64'd1));
    return v;
  endfunction

  function automatic cce_pkg::cfg_t random_settings();
    cce_pkg::cfg_t s;
    case ($urandom_range(0, 9))
      0:       s.width_bytes = 4'd0;
      1:       s.width_bytes = 4'($urandom_range(9, 15));
      default: s.width_bytes = 4'($urandom_range(1, 8));
    endcase
    s.polynomial         = corner_or_random();
    s.init_value         = corner_or_random();
    s.reflect_in         = 1'($urandom_range(0, 1));
    s.reflect_out        = 1'($urandom_range(0, 1));
    s.xor_out            = corner_or_random();
    s.register_reflected = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Register write on the next rising edge; called and returning at a falling edge.
  task automatic write_reg(input logic [cce_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] value);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    @(negedge clk);
  endtask

  task automatic apply_settings(input cce_pkg::cfg_t s);
    write_reg(cce_pkg::REG_WIDTH_BYTES, pad_register(64'(s.width_bytes), 4));
    write_reg(cce_pkg::REG_POLYNOMIAL, s.polynomial);
    write_reg(cce_pkg::REG_INIT_VALUE, s.init_value);
    write_reg(cce_pkg::REG_REFLECT_IN, pad_register(64'(s.reflect_in), 1));
    write_reg(cce_pkg::REG_REFLECT_OUT, pad_register(64'(s.reflect_out), 1));
    write_reg(cce_pkg::REG_XOR_OUT, s.xor_out);
    write_reg(cce_pkg::REG_REGISTER_REFLECTED,
              pad_register(64'(s.register_reflected), 1));
    cfg_write_en <= 1'b0;
  endtask

  // Offers one byte, with an occasional gap before it, and returns at the falling
  // edge after its transaction.
  task automatic send_byte(input logic [7:0] data, input logic last);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= data;
    byte_if.last_byte <= last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int unsigned len, input logic close);
    int unsigned i;
    for (i = 0; i < len; i++) send_byte(random_byte(), close && (i == len - 1));
  endtask

  // Stops offering bytes, lets every owed CRC drain and lets the pipeline empty.
  task automatic wait_quiet();
    byte_if.valid <= 1'b0;
    while (crc_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    cce_pkg::cfg_t s;
    int unsigned   i;
    int unsigned   phase;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    byte_if.last_byte = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings (CRC-32): single-byte messages at both byte extremes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // The usual check string "123456789".
    for (i = 0; i < 9; i++) send_byte(8'h31 + 8'(i), i == 8);
    wait_quiet();

    // Narrowest width, no reflection, left-shifting register; the unused index too.
    write_reg(REG_SPARE, rand64());
    s = '{width_bytes: 4'd1, polynomial: 64'h07, init_value: '0, reflect_in: 1'b0,
          reflect_out: 1'b0, xor_out: '0, register_reflected: 1'b0};
    apply_settings(s);
    for (i = 0; i < 9; i++) send_byte(8'h31 + 8'(i), i == 8);
    wait_quiet();

    // Widest register, right-shifting, every other field at all ones.
    s = '{width_bytes: 4'd8, polynomial: '1, init_value: '1, reflect_in: 1'b1,
          reflect_out: 1'b1, xor_out: '1, register_reflected: 1'b1};
    apply_settings(s);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    wait_quiet();

    // Width code zero acts as one byte; the message stays open across new settings
    // with an out-of-range width code.
    s = '{width_bytes: 4'd0, polynomial: rand64(), init_value: rand64(), reflect_in: 1'b0,
          reflect_out: 1'b1, xor_out: rand64(), register_reflected: 1'b1};
    apply_settings(s);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    wait_quiet();
    s = '{width_bytes: 4'd15, polynomial: rand64(), init_value: rand64(), reflect_in: 1'b1,
          reflect_out: 1'b0, xor_out: rand64(), register_reflected: 1'b0};
    apply_settings(s);
    send_byte(8'h3C, 1'b1);

    // Random settings, each followed by a batch of messages.
    phase = 0;
    while (items_sent < ITEM_TARGET - CALM_ITEMS) begin
      wait_quiet();
      apply_settings(random_settings());
      if (phase == PRESSURE_PHASE) begin
        // Short messages while the receiver holds off, so the input backs up.
        hold_off_req = 1'b1;
        repeat (40) send_byte(random_byte(), 1'b1);
      end
      repeat ($urandom_range(2, 8)) send_message(message_length(), 1'b1);
      // Now and then the next settings land in the middle of a message.
      if ($urandom_range(0, 3) == 0) send_message($urandom_range(1, 6), 1'b0);
      phase++;
    end

    // Final stretch at full rate on both sides.
    wait_quiet();
    apply_settings(random_settings());
    idling_on = 1'b0;
    while (items_sent < ITEM_TARGET) send_message(message_length(), 1'b1);
    wait_quiet();

    if (mismatch_count == 0 && crc_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/cce_pkg.sv
design/cce_if.sv
design/cce_cfg_regs.sv
design/cce_step.sv
design/configurable_crc_engine.sv
tb/crc_stream_checker.sv
tb/configurable_crc_engine_tb.sv
